>>> hw/rtl/box_filter_average_macros.svh
// assertion macros shared by the box filter rtl
`ifndef BOX_FILTER_AVERAGE_MACROS_SVH
`define BOX_FILTER_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is high
`define BFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled while reset is high
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bfa_pkg.sv
// shared constants and types for the box filter
package bfa_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  // configuration register widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;

  // configuration reset values
  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd512;
  localparam logic [RADIUS_REG_W-1:0] RST_RADIUS       = 2'd1;

  // stream field widths
  localparam int PIXEL_W      = 16;
  localparam int AVERAGE_W    = 20;
  localparam int CENTER_COL_W = 10;
  localparam int CENTER_ROW_W = 12;
  localparam int S_TDATA_W    = PIXEL_W;
  localparam int M_FIELDS_W   = AVERAGE_W + CENTER_COL_W + CENTER_ROW_W;
  localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SUM,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } seq_state_t;

endpackage

>>> hw/rtl/bfa_ram.sv
// generic simple dual-port ram with registered read
module bfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/box_filter_average.sv
// top level of the streaming two-dimensional box filter
//
// usage:
//  - pixels enter in raster order on the s_ group; s_tuser marks the top-left
//    pixel of a frame and restarts the column and row count
//  - each interior pixel (column >= 2r and row >= 2r) yields one transfer on
//    the m_ group: the window mean with 4 fraction bits, the window centre and
//    m_tlast on the final pixel of the frame; border pixels yield nothing
//  - configuration (width, height, radius) is written on cfg_we/cfg_index/
//    cfg_wdata while no pixel is in flight
//  - a new pixel is taken only once the previous one has left the chain;
//    each pixel walks the chain line store read, store write and window
//    shift, window sum, reciprocal multiply, quotient correction, and the
//    line store read and write never overlap
//  - the line store keeps 2*MAX_RADIUS rows of one column per word, so one
//    read and one write per pixel move the whole column
//  - reset clears the counters, window and output valid at once; the line
//    store is not cleared and needs no clearing pass
//  - when the receiver stalls, the result waits in the output register; the
//    next pixel is still taken and worked on, and only its final step holds
//    until the output register is free
`include "box_filter_average_macros.svh"

module box_filter_average #(
  parameter int MAX_WIDTH  = bfa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bfa_pkg::DEF_MAX_RADIUS,
  parameter int MAX_HEIGHT = bfa_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = bfa_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bfa_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] pixel
  input  logic                            s_tuser,   // first_of_frame
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bfa_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] average, [29:20] center_col,
                                                     // [41:30] center_row, rest zero
  output logic                            m_tlast,   // last_of_frame
  input  logic                            cfg_we,
  input  logic [bfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bfa_pkg::*;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WE_W       = $clog2(MAX_WIDTH + 1);
  localparam int HE_W       = $clog2(MAX_HEIGHT + 1);
  localparam int R_W        = $clog2(MAX_RADIUS + 1);
  localparam int WIN_DIM    = 2 * MAX_RADIUS + 1;
  localparam int STORE_ROWS = 2 * MAX_RADIUS;
  localparam int STORE_W    = STORE_ROWS * PIXEL_BITS;
  localparam int PS_W       = PIXEL_BITS + $clog2(WIN_DIM);
  localparam int SUM_W      = PIXEL_BITS + $clog2(WIN_DIM * WIN_DIM);
  localparam int X_W        = SUM_W + 4;
  localparam int N_W        = $clog2(WIN_DIM * WIN_DIM + 1);
  localparam int CMP_W      = (X_W > AVERAGE_W) ? X_W : AVERAGE_W;
  localparam logic [AVERAGE_W-1:0] AVG_SAT = '1;

  // configuration registers
  logic [WIDTH_REG_W-1:0]  cfg_width;
  logic [HEIGHT_REG_W-1:0] cfg_height;
  logic [RADIUS_REG_W-1:0] cfg_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RST_IMAGE_WIDTH;
      cfg_height <= RST_IMAGE_HEIGHT;
      cfg_radius <= RST_RADIUS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= cfg_wdata[HEIGHT_REG_W-1:0];
        REG_RADIUS:       cfg_radius <= cfg_wdata[RADIUS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero width or height acts as one, values above the maximum are clamped
  logic [WE_W-1:0] eff_w;
  logic [HE_W-1:0] eff_h;
  logic [R_W-1:0]  r_eff;

  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WE_W'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      eff_w = WE_W'(MAX_WIDTH);
    end else begin
      eff_w = WE_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HE_W'(1);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      eff_h = HE_W'(MAX_HEIGHT);
    end else begin
      eff_h = HE_W'(cfg_height);
    end
    if (32'(cfg_radius) > MAX_RADIUS) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(cfg_radius);
    end
  end

  // divider constants per radius: n = (2r+1)^2 and floor(2^X_W / n)
  logic [X_W:0]   rcp_tab [MAX_RADIUS+1];
  logic [N_W-1:0] n_tab   [MAX_RADIUS+1];

  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_div_const
    localparam logic [X_W:0]   RCP = (X_W+1)'({1'b1, {X_W{1'b0}}} / ((2*g+1) * (2*g+1)));
    localparam logic [N_W-1:0] NV  = N_W'((2*g+1) * (2*g+1));
    assign rcp_tab[g] = RCP;
    assign n_tab[g]   = NV;
  end

  // sequencer
  seq_state_t state, state_next;
  logic       accept;
  logic       out_free;
  logic       store_re;
  logic       store_we;
  logic       out_load;
  logic       interior_q;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_SUM;
      ST_SUM:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_FIX;
      ST_FIX:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    store_re = (state == ST_IDLE) && s_tvalid;
    store_we = (state == ST_FETCH);
    out_load = (state == ST_OUT) && out_free && interior_q;
  end

  // position of the incoming pixel and the position after it
  logic [COL_W-1:0] col_count, row_count_unused_guard;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] y0;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;

  assign row_count_unused_guard = col_count;

  always_comb begin
    logic [ROW_W:0] y_pre;
    logic [COL_W:0] c_inc;
    logic [ROW_W:0] y_inc;
    if (s_tuser) begin
      c0    = '0;
      y_pre = '0;
    end else if (32'(col_count) >= 32'(eff_w)) begin
      // width lowered below the current column: continue on the next row
      c0    = '0;
      y_pre = (ROW_W+1)'(row_count) + (ROW_W+1)'(1);
    end else begin
      c0    = row_count_unused_guard;
      y_pre = (ROW_W+1)'(row_count);
    end
    if (32'(y_pre) >= 32'(eff_h)) begin
      y0 = '0;
    end else begin
      y0 = y_pre[ROW_W-1:0];
    end
    c_inc = (COL_W+1)'(c0) + (COL_W+1)'(1);
    y_inc = (ROW_W+1)'(y0) + (ROW_W+1)'(1);
    if (32'(c_inc) >= 32'(eff_w)) begin
      col_next = '0;
      if (32'(y_inc) >= 32'(eff_h)) begin
        row_next = '0;
      end else begin
        row_next = y_inc[ROW_W-1:0];
      end
    end else begin
      col_next = c_inc[COL_W-1:0];
      row_next = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // per-pixel context captured at the input transfer
  logic [PIXEL_BITS-1:0]   pix_q;
  logic [COL_W-1:0]        col_q;
  logic [R_W-1:0]          r_q;
  logic                    last_q;
  logic [CENTER_COL_W-1:0] ccol_q;
  logic [CENTER_ROW_W-1:0] crow_q;
  logic [X_W:0]            rcp_q;
  logic [N_W-1:0]          n_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q      <= PIXEL_BITS'(s_tdata);
      col_q      <= c0;
      r_q        <= r_eff;
      interior_q <= (32'(c0) >= 32'({r_eff, 1'b0})) && (32'(y0) >= 32'({r_eff, 1'b0}));
      last_q     <= (32'(c0) == 32'(eff_w) - 32'd1) && (32'(y0) == 32'(eff_h) - 32'd1);
      ccol_q     <= CENTER_COL_W'(c0 - COL_W'(r_eff));
      crow_q     <= CENTER_ROW_W'(y0 - ROW_W'(r_eff));
      rcp_q      <= rcp_tab[r_eff];
      n_q        <= n_tab[r_eff];
    end
  end

  // line store: one word per column, slot k holds the pixel k+1 rows above
  logic [STORE_W-1:0] store_rd;
  logic [STORE_W-1:0] store_wr;

  assign store_wr = {store_rd[(STORE_ROWS-1)*PIXEL_BITS-1:0], pix_q};

  bfa_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (col_q),
    .wr_data (store_wr),
    .rd_en   (store_re),
    .rd_addr (c0),
    .rd_data (store_rd)
  );

  // column sums of the new window column for every radius, bottom row upward
  logic [PS_W-1:0] part_new [MAX_RADIUS+1];

  always_comb begin
    part_new[0] = PS_W'(pix_q);
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      part_new[k] = part_new[k-1]
                  + PS_W'(store_rd[(2*k-2)*PIXEL_BITS +: PIXEL_BITS])
                  + PS_W'(store_rd[(2*k-1)*PIXEL_BITS +: PIXEL_BITS]);
    end
  end

  // window held as column sums; shifts left once per pixel
  logic [PS_W-1:0] col_part [WIN_DIM][MAX_RADIUS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WIN_DIM; j++) begin
        for (int k = 0; k <= MAX_RADIUS; k++) begin
          col_part[j][k] <= '0;
        end
      end
    end else if (state == ST_FETCH) begin
      for (int j = 0; j < WIN_DIM - 1; j++) begin
        col_part[j] <= col_part[j+1];
      end
      col_part[WIN_DIM-1] <= part_new;
    end
  end

  // window sum over the newest 2r+1 columns
  logic [SUM_W-1:0] win_sum;

  always_comb begin
    win_sum = '0;
    for (int j = 0; j < WIN_DIM; j++) begin
      if (j + 2 * int'(r_q) >= WIN_DIM - 1) begin
        win_sum = win_sum + SUM_W'(col_part[j][r_q]);
      end
    end
  end

  // divide sum*16 by n: reciprocal estimate, then one correction step
  logic [X_W-1:0]   xnum;
  logic [2*X_W:0]   prod;
  logic [X_W-1:0]   q_est;
  logic [X_W-1:0]   q_q;
  logic [X_W-1:0]   qn_q;
  logic [X_W-1:0]   rem;
  logic [X_W-1:0]   q_fin;
  logic [AVERAGE_W-1:0] avg;

  assign q_est = prod[X_W +: X_W];

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      xnum <= {win_sum, 4'b0000};
    end
    if (state == ST_MUL) begin
      prod <= xnum * rcp_q;
    end
    if (state == ST_FIX) begin
      q_q  <= q_est;
      qn_q <= X_W'(q_est * n_q);
    end
  end

  always_comb begin
    rem   = xnum - qn_q;
    q_fin = (rem >= X_W'(n_q)) ? q_q + X_W'(1) : q_q;
    if (CMP_W'(q_fin) > CMP_W'(AVG_SAT)) begin
      avg = AVG_SAT;
    end else begin
      avg = AVERAGE_W'(q_fin);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W - M_FIELDS_W){1'b0}}, crow_q, ccol_q, avg};
      m_tlast <= last_q;
    end
  end

  `BFA_ASSERT_NEXT(a_fetch_writes, clk, rst, accept, store_we, "store write must follow accepted pixel")
  `BFA_ASSERT_IMPL(a_port_excl, clk, rst, store_re, !store_we, "line store read and write overlap")
  `BFA_ASSERT_IMPL(a_rem_bound, clk, rst, state == ST_OUT, rem < (X_W'(n_q) << 1), "reciprocal estimate off by more than one")
  `BFA_ASSERT_IMPL(a_valid_src, clk, rst, $rose(m_tvalid), $past(state) == ST_OUT, "result raised outside final step")

endmodule
